[design/rlf_pkg.sv]
// shared types and constants of the page framebuffer line-fill engine
`timescale 1ns / 1ps

package rlf_pkg;

	// signed working width of the coordinate math, wide enough for any mapped sum
	localparam int CW = 20;
	// clipped coordinate and count width, covers the full panel size range
	localparam int PIX_W = 9;
	// byte address width before the depth check, covers the full panel size range
	localparam int ADDR_W = 13;
	localparam int FRAME_DEPTH = 1024;
	localparam int FRAME_AW = 10;

	localparam logic [1:0] REQ_HLINE = 2'd0;
	localparam logic [1:0] REQ_VLINE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [1:0] COLOR_DARK  = 2'd0;
	localparam logic [1:0] COLOR_LIGHT = 2'd1;
	localparam logic [1:0] COLOR_INV   = 2'd2;
	localparam logic [1:0] COLOR_NOP   = 2'd3;

	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	// line mapped onto panel coordinates
	typedef struct packed {
		logic                 vert;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] len;
	} rot_t;

	// clipped job handed to the fill engine
	typedef struct packed {
		logic                draw;
		logic                read;
		logic                vert;
		logic [1:0]          op;
		logic [PIX_W-1:0]    fixed;
		logic [PIX_W-1:0]    start;
		logic [PIX_W-1:0]    count;
		logic [FRAME_AW-1:0] read_addr;
	} span_t;

	typedef struct packed {
		logic       busy;
		logic [7:0] rdata;
	} eng_stat_t;

endpackage

[design/rlf_intf.sv]
// channel interfaces: request, response and configuration write
`timescale 1ns / 1ps

interface rlf_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic signed [15:0] x_coord;
	logic signed [15:0] y_coord;
	logic signed [15:0] length;
	logic [1:0]         color;
	logic [9:0]         read_addr;

	modport source (output valid, req_type, x_coord, y_coord, length, color, read_addr,
		input ready);
	modport sink (input valid, req_type, x_coord, y_coord, length, color, read_addr,
		output ready);
endinterface

interface rlf_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic [7:0] drawn_length;

	modport source (output valid, read_data, drawn_length, input ready);
	modport sink (input valid, read_data, drawn_length, output ready);
endinterface

interface rlf_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] rotation;

	modport source (output valid, rotation, input ready);
	modport sink (input valid, rotation, output ready);
endinterface

[design/rlf_rotate.sv]
// rotation mapping of a logical line onto panel coordinates
`timescale 1ns / 1ps

module rlf_rotate import rlf_pkg::*; #(
	parameter int PANEL_WIDTH = 128,
	parameter int PANEL_HEIGHT = 64
) (
	input  logic [1:0]         rotation,
	input  logic [1:0]         req_type,
	input  logic signed [15:0] x_coord,
	input  logic signed [15:0] y_coord,
	input  logic signed [15:0] length,
	output rot_t               rot
);

	localparam logic signed [CW-1:0] W_C = CW'(PANEL_WIDTH);
	localparam logic signed [CW-1:0] H_C = CW'(PANEL_HEIGHT);
	localparam logic signed [CW-1:0] ONE = CW'(1);

	logic signed [CW-1:0] xe, ye, xs, ys, ln;

	assign xe = {{(CW-16){x_coord[15]}}, x_coord};
	assign ye = {{(CW-16){y_coord[15]}}, y_coord};
	assign ln = {{(CW-16){length[15]}}, length};
	// odd rotations swap the axes
	assign xs = rotation[0] ? ye : xe;
	assign ys = rotation[0] ? xe : ye;

	always_comb begin
		rot.x = xs;
		rot.y = ys;
		rot.len = ln;
		rot.vert = ((req_type == REQ_HLINE) == rotation[0]);
		if (req_type == REQ_HLINE) begin
			case (rotation)
				ROT_90: begin
					rot.x = W_C - ONE - xs;
				end
				ROT_180: begin
					rot.x = W_C - xs - ln;
					rot.y = H_C - ONE - ys;
				end
				ROT_270: begin
					rot.y = H_C - ys - ln;
				end
				default: begin
				end
			endcase
		end else begin
			case (rotation)
				ROT_90: begin
					rot.x = W_C - xs - ln;
				end
				ROT_180: begin
					rot.x = W_C - ONE - xs;
					rot.y = H_C - ys - ln;
				end
				ROT_270: begin
					rot.y = H_C - ONE - ys;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[design/rlf_clip.sv]
// clipping of a mapped line against the panel and job classification
`timescale 1ns / 1ps

module rlf_clip import rlf_pkg::*; #(
	parameter int PANEL_WIDTH = 128,
	parameter int PANEL_HEIGHT = 64
) (
	input  rot_t                rot,
	input  logic [1:0]          req_type,
	input  logic [1:0]          color,
	input  logic [FRAME_AW-1:0] read_addr,
	output span_t               span
);

	localparam logic signed [CW-1:0] W_C = CW'(PANEL_WIDTH);
	localparam logic signed [CW-1:0] H_C = CW'(PANEL_HEIGHT);

	logic signed [CW-1:0] fix, s, s1, n1, n2, lim_f, lim_a;
	logic                 in_fix, is_line;

	// fixed axis and running axis depend on the drawn direction
	assign fix   = rot.vert ? rot.x : rot.y;
	assign s     = rot.vert ? rot.y : rot.x;
	assign lim_f = rot.vert ? W_C : H_C;
	assign lim_a = rot.vert ? H_C : W_C;

	assign s1 = s[CW-1] ? '0 : s;
	assign n1 = s[CW-1] ? rot.len + s : rot.len;
	assign n2 = (s1 + n1 > lim_a) ? lim_a - s1 : n1;

	assign in_fix  = !fix[CW-1] && (fix < lim_f);
	assign is_line = (req_type == REQ_HLINE) || (req_type == REQ_VLINE);

	always_comb begin
		span.draw      = is_line && in_fix && !n2[CW-1] && (n2 != '0) && (color != COLOR_NOP);
		span.read      = (req_type == REQ_READ);
		span.vert      = rot.vert;
		span.op        = color;
		span.fixed     = fix[PIX_W-1:0];
		span.start     = s1[PIX_W-1:0];
		span.count     = n2[PIX_W-1:0];
		span.read_addr = read_addr;
	end

endmodule

[design/rlf_fill.sv]
// framebuffer memory with clearing pass and one-byte-per-cycle read-modify-write
`timescale 1ns / 1ps

module rlf_fill import rlf_pkg::*; #(
	parameter int PANEL_WIDTH = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  span_t     span,
	output eng_stat_t stat
);

	localparam logic [2:0] E_CLEAR = 3'd0;
	localparam logic [2:0] E_IDLE  = 3'd1;
	localparam logic [2:0] E_SETUP = 3'd2;
	localparam logic [2:0] E_RUN   = 3'd3;
	localparam logic [2:0] E_DRAIN = 3'd4;

	localparam logic [7:0]        FULL   = 8'hFF;
	localparam logic [ADDR_W-1:0] W_A    = ADDR_W'(PANEL_WIDTH);
	localparam logic [PIX_W-1:0]  W_P    = PIX_W'(PANEL_WIDTH);
	localparam logic [ADDR_W-1:0] DEPTH  = ADDR_W'(FRAME_DEPTH);
	localparam logic [FRAME_AW-1:0] LAST_ENTRY = FRAME_AW'(FRAME_DEPTH - 1);

	function automatic logic [7:0] apply_op(input logic [7:0] d, input logic [7:0] m,
		input logic [1:0] op);
		logic [7:0] r;
		case (op)
			COLOR_DARK:  r = d & ~m;
			COLOR_LIGHT: r = d | m;
			COLOR_INV:   r = d ^ m;
			default:     r = d;
		endcase
		return r;
	endfunction

	logic [7:0] mem_q [FRAME_DEPTH];
	logic [7:0] rd_q;

	logic [2:0]          state_q;
	logic [FRAME_AW-1:0] clr_q;
	span_t               job_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [PIX_W-1:0]    step_q;
	logic [PIX_W-1:0]    left_q;
	logic                first_q;
	logic                wr_en_q;
	logic [7:0]          m_first_q, m_mid_q, m_last_q;
	logic [7:0]          rdata_q;

	logic                v_s1;
	logic                wr_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic [7:0]          mask_s1;

	// setup values
	logic [PIX_W-4:0]    page_row, page_first, page_last;
	logic [PIX_W-1:0]    y_end;
	logic [ADDR_W-1:0]   base_row, base_col;
	logic [7:0]          bit_row, mask_col_first, mask_col_last, mask_now;

	assign page_row       = job_q.fixed[PIX_W-1:3];
	assign y_end          = job_q.start + job_q.count - PIX_W'(1);
	assign page_first     = job_q.start[PIX_W-1:3];
	assign page_last      = y_end[PIX_W-1:3];
	assign base_row       = ADDR_W'(page_row) * W_A + ADDR_W'(job_q.start);
	assign base_col       = ADDR_W'(page_first) * W_A + ADDR_W'(job_q.fixed);
	assign bit_row        = 8'h01 << job_q.fixed[2:0];
	// partial first and last pages of a column
	assign mask_col_first = FULL << job_q.start[2:0];
	assign mask_col_last  = FULL >> (3'd7 - y_end[2:0]);

	assign mask_now = m_mid_q & (first_q ? m_first_q : FULL)
		& ((left_q == '0) ? m_last_q : FULL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_CLEAR;
			clr_q   <= '0;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= (state_q == E_RUN);
			case (state_q)
				E_CLEAR: begin
					clr_q <= clr_q + FRAME_AW'(1);
					if (clr_q == LAST_ENTRY) begin
						state_q <= E_IDLE;
					end
				end
				E_IDLE: begin
					if (start) begin
						state_q <= E_SETUP;
					end
				end
				E_SETUP: begin
					state_q <= E_RUN;
				end
				E_RUN: begin
					if (left_q == '0) begin
						state_q <= E_DRAIN;
					end
				end
				E_DRAIN: begin
					state_q <= E_IDLE;
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == E_IDLE && start) begin
			job_q <= span;
		end
		if (state_q == E_SETUP) begin
			first_q <= 1'b1;
			wr_en_q <= !job_q.read;
			if (job_q.read) begin
				addr_q    <= ADDR_W'(job_q.read_addr);
				step_q    <= PIX_W'(1);
				left_q    <= '0;
				m_first_q <= FULL;
				m_mid_q   <= FULL;
				m_last_q  <= FULL;
			end else if (job_q.vert) begin
				addr_q    <= base_col;
				step_q    <= W_P;
				left_q    <= PIX_W'(page_last - page_first);
				m_first_q <= mask_col_first;
				m_mid_q   <= FULL;
				m_last_q  <= mask_col_last;
			end else begin
				addr_q    <= base_row;
				step_q    <= PIX_W'(1);
				left_q    <= job_q.count - PIX_W'(1);
				m_first_q <= bit_row;
				m_mid_q   <= bit_row;
				m_last_q  <= bit_row;
			end
		end
		if (state_q == E_RUN) begin
			addr_q  <= addr_q + ADDR_W'(step_q);
			left_q  <= left_q - PIX_W'(1);
			first_q <= 1'b0;
			addr_s1 <= addr_q;
			mask_s1 <= mask_now;
			// bytes beyond the store are counted but never written
			wr_s1   <= wr_en_q && (addr_q < DEPTH);
		end
		if (v_s1) begin
			rdata_q <= rd_q;
		end
	end

	// memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (state_q == E_CLEAR) begin
			mem_q[clr_q] <= 8'h00;
		end else if (v_s1 && wr_s1) begin
			mem_q[addr_s1[FRAME_AW-1:0]] <= apply_op(rd_q, mask_s1, job_q.op);
		end
		rd_q <= mem_q[addr_q[FRAME_AW-1:0]];
	end

	assign stat.busy  = (state_q != E_IDLE);
	assign stat.rdata = rdata_q;

endmodule

[design/rotated_line_fill_page_framebuffer_core.sv]
// top level of the rotated line-fill engine over a page-organized framebuffer
`timescale 1ns / 1ps

// Line-fill engine over a 1024-byte monochrome framebuffer, eight vertical pixels
// per byte, byte address (y/8)*PANEL_WIDTH + x. Requests draw a horizontal or
// vertical line through the rotation register, clipped to the panel, or read one
// byte; each request gives one response. The framebuffer sits in one memory with
// a single read-modify-write path that handles one byte per cycle. A line touches
// the clipped length in bytes when drawn horizontally on the panel, up to
// PANEL_WIDTH, and the pages spanned when drawn vertically, up to PANEL_HEIGHT/8;
// a read touches one byte; a line that draws nothing or an unused request type
// does not start the fill engine. A new request is taken only after the previous
// one's response is loaded, and a response that is not taken holds the following
// one back. After reset a clearing pass zeroes the memory, and no request is
// taken until it ends; rotation writes are taken at any time and should be made
// while the block is idle.

module rotated_line_fill_page_framebuffer_core import rlf_pkg::*; #(
	parameter int PANEL_WIDTH = 128,
	parameter int PANEL_HEIGHT = 64
) (
	input logic     clk,
	input logic     arst_n,
	rlf_cfg_if.sink cfg,
	rlf_req_if.sink req,
	rlf_rsp_if.source rsp
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MAP   = 3'd1;
	localparam logic [2:0] ST_CLIP  = 3'd2;
	localparam logic [2:0] ST_START = 3'd3;
	localparam logic [2:0] ST_RUN   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]          state_q;
	logic [1:0]          rotation_q;
	logic [1:0]          req_type_q;
	logic signed [15:0]  x_q, y_q, len_q;
	logic [1:0]          color_q;
	logic [FRAME_AW-1:0] raddr_q;
	rot_t                rot_c, rot_q;
	span_t               span_c, span_q;
	eng_stat_t           stat;
	logic                start;
	logic                out_valid_q;
	logic [7:0]          read_data_q, drawn_q;
	logic                load;
	logic [7:0]          drawn_sat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= ROT_0;
		end else if (cfg.valid) begin
			rotation_q <= cfg.rotation;
		end
	end

	rlf_rotate #(
		.PANEL_WIDTH(PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT)
	) u_rotate (
		.rotation(rotation_q),
		.req_type(req_type_q),
		.x_coord(x_q),
		.y_coord(y_q),
		.length(len_q),
		.rot(rot_c)
	);

	rlf_clip #(
		.PANEL_WIDTH(PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT)
	) u_clip (
		.rot(rot_q),
		.req_type(req_type_q),
		.color(color_q),
		.read_addr(raddr_q),
		.span(span_c)
	);

	rlf_fill #(
		.PANEL_WIDTH(PANEL_WIDTH)
	) u_fill (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.span(span_q),
		.stat(stat)
	);

	assign req.ready = (state_q == ST_IDLE) && !stat.busy;
	assign start     = (state_q == ST_START) && (span_q.read || span_q.draw);
	assign load      = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);
	assign drawn_sat = span_q.count[PIX_W-1] ? 8'hFF : span_q.count[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid && req.ready) begin
						state_q <= ST_MAP;
					end
				end
				ST_MAP: begin
					state_q <= ST_CLIP;
				end
				ST_CLIP: begin
					state_q <= ST_START;
				end
				ST_START: begin
					state_q <= start ? ST_RUN : ST_DONE;
				end
				ST_RUN: begin
					if (!stat.busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_q <= req.req_type;
			x_q        <= req.x_coord;
			y_q        <= req.y_coord;
			len_q      <= req.length;
			color_q    <= req.color;
			raddr_q    <= req.read_addr;
		end
		if (state_q == ST_MAP) begin
			rot_q <= rot_c;
		end
		if (state_q == ST_CLIP) begin
			span_q <= span_c;
		end
		if (load) begin
			read_data_q <= span_q.read ? stat.rdata : 8'h00;
			drawn_q     <= span_q.draw ? drawn_sat : 8'h00;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.read_data    = read_data_q;
	assign rsp.drawn_length = drawn_q;

	// a taken request always moves into the mapping stage
	a_accept_map: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q == ST_MAP)
		else $error("accepted request did not enter mapping");

	// the engine goes busy right after a start
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> stat.busy)
		else $error("fill engine did not start");

	// engine finishing moves the sequencer to the response
	a_run_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && !stat.busy |=> state_q == ST_DONE)
		else $error("finished job did not reach response");

	// a response carries read data or a drawn count, never both
	a_rsp_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.read_data == 8'h00 || rsp.drawn_length == 8'h00))
		else $error("response has both read data and drawn count");

endmodule
